// ===== sv/ars_pkg.sv =====
// Shared types, constants and AES byte functions for the AES-round AEAD engine.
// No dependencies; used by ars_aes_round and the top level.
`timescale 1ns / 1ps
`default_nettype none

package ars_pkg;

    typedef logic [127:0] blk_t;

    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_AD   = 2'd1,
        OP_MSG  = 2'd2,
        OP_TAG  = 2'd3
    } opcode_t;

    localparam int CFG_INDEX_W = 3;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY0      = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY1      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY2      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY3      = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_LO  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE_HI  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_DIRECTION = 3'd6;

    // Init constants, byte 0 in the low bits
    localparam blk_t Z0_BLK = 128'h428a2f98_d728ae22_71374491_23ef65cd;
    localparam blk_t Z1_BLK = 128'hb5c0fbcf_ec4d3b2f_e9b5dba5_8189dbbc;

    localparam int ROUNDS_W    = 5;
    localparam logic [ROUNDS_W-1:0] SETUP_ROUNDS = 5'd16;
    localparam int STEP_W      = 3;
    localparam logic [STEP_W-1:0] LAST_STEP = 3'd6;   // six AES rounds, then commit

    localparam logic [7:0] SBOX [0:255] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Length block: total bytes times eight as a 128-bit little-endian value
    function automatic blk_t bitlen(input logic [63:0] total);
        return {61'd0, total, 3'd0};
    endfunction

endpackage

`default_nettype wire

// ===== sv/ars_aes_round.sv =====
// One AES encryption round: MixColumns(ShiftRows(SubBytes(a))) ^ k.
// Depends on ars_pkg (sbox, xtime).
`timescale 1ns / 1ps
`default_nettype none

module ars_aes_round (
    input  wire logic [127:0] a,
    input  wire logic [127:0] k,
    output      logic [127:0] y
);

    logic [127:0] t;
    logic [127:0] m;

    for (genvar c = 0; c < 4; c++) begin : g_col
        for (genvar r = 0; r < 4; r++) begin : g_row
            assign t[8*(r+4*c) +: 8] = ars_pkg::sbox(a[8*(r+4*((c+r)%4)) +: 8]);
        end

        logic [7:0] a0, a1, a2, a3;
        assign a0 = t[8*(4*c)   +: 8];
        assign a1 = t[8*(4*c+1) +: 8];
        assign a2 = t[8*(4*c+2) +: 8];
        assign a3 = t[8*(4*c+3) +: 8];

        assign m[8*(4*c)   +: 8] = ars_pkg::xtime(a0) ^ ars_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        assign m[8*(4*c+1) +: 8] = a0 ^ ars_pkg::xtime(a1) ^ ars_pkg::xtime(a2) ^ a2 ^ a3;
        assign m[8*(4*c+2) +: 8] = a0 ^ a1 ^ ars_pkg::xtime(a2) ^ ars_pkg::xtime(a3) ^ a3;
        assign m[8*(4*c+3) +: 8] = ars_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ ars_pkg::xtime(a3);
    end

    assign y = m ^ k;

endmodule

`default_nettype wire

// ===== sv/aead_stream_cipher_aes_round_unit.sv =====
// AES-round authenticated cipher engine (seven-word state), top level.
// Depends on ars_pkg and ars_aes_round.
//
// Usage:
//  - cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes key words 0..3,
//    nonce low/high and direction. Always ready; write only while the engine is idle.
//  - in channel takes one word: opcode, payload (up to 8 bytes, byte 0 low), byte_count.
//    in_ready is high only in idle; the engine works on one word at a time.
//  - out channel returns one word per init or data word, four tag words for finalize.
//    Results are held in registers until out_ready; a stall just holds the engine.
//  - All work runs through one AES round unit, one round per cycle. A state update
//    is six rounds, then a commit; the keystream is two rounds.
//  - Init runs 16 state updates, then the key fold. A data word takes its bytes one at
//    a time, with a keystream made when a message block starts and one update per
//    block absorbed (on a full block or an operation change). Finalize runs 16 updates,
//    after one that pads a partial block. Tag words then go out one per cycle while out_ready.
//  - Rejected data words (byte_count above 8) answer in the next cycle and change nothing.
//  - Reset clears the state, buffers, byte totals and config registers; out_valid drops.
`timescale 1ns / 1ps
`default_nettype none

module aead_stream_cipher_aes_round_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data,

    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [63:0] payload,
    input  wire logic [3:0]  byte_count,

    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic [63:0] out_data,
    output      logic [3:0]  out_bytes,
    output      logic        is_tag,
    output      logic        last,
    output      logic        status
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_UPD  = 7'b0000010,
        ST_KS   = 7'b0000100,
        ST_BYTE = 7'b0001000,
        ST_FOLD = 7'b0010000,
        ST_FIN  = 7'b0100000,
        ST_RESP = 7'b1000000
    } state_t;

    // config
    logic [63:0] key_reg [4];
    logic [63:0] nonce_lo_reg, nonce_hi_reg;
    logic        dir_reg;

    // engine state
    state_t                      state_reg, state_next;
    ars_pkg::blk_t               s_reg [7];
    ars_pkg::blk_t               s_next [7];
    ars_pkg::blk_t               new_reg [6];
    ars_pkg::blk_t               new_next [6];
    logic [255:0]                pend_reg, pend_next;
    logic [255:0]                ks_reg, ks_next;     // keystream; holds tag words after finalize
    logic [5:0]                  fill_reg, fill_next;
    logic [63:0]                 ad_total_reg, ad_total_next;
    logic [63:0]                 msg_total_reg, msg_total_next;
    ars_pkg::opcode_t            prev_op_reg, prev_op_next;

    // sequencer
    ars_pkg::opcode_t            op_reg, op_next;
    logic [63:0]                 pay_reg, pay_next;
    logic [3:0]                  n_reg, n_next;
    logic [3:0]                  bidx_reg, bidx_next;
    logic [ars_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [ars_pkg::ROUNDS_W-1:0] rounds_reg, rounds_next;
    logic                        ks_fresh_reg, ks_fresh_next;
    logic                        tag_len_reg, tag_len_next;
    logic [1:0]                  widx_reg, widx_next;

    // result
    logic [63:0]                 res_data_reg, res_data_next;
    logic [3:0]                  res_bytes_reg, res_bytes_next;
    logic                        res_tag_reg, res_tag_next;
    logic                        res_status_reg, res_status_next;

    ars_pkg::blk_t unit_a, unit_k, unit_y;
    ars_pkg::blk_t k0_blk, k1_blk, n_blk;

    logic [7:0] cur_byte, ks_byte, enc_byte, push_byte;

    assign k0_blk = {key_reg[1], key_reg[0]};
    assign k1_blk = {key_reg[3], key_reg[2]};
    assign n_blk  = {nonce_hi_reg, nonce_lo_reg};

    ars_aes_round u_round (
        .a (unit_a),
        .k (unit_k),
        .y (unit_y)
    );

    // Operand select for the shared round unit; X0/X1 always come from pend_reg
    always_comb begin
        unit_a = '0;
        unit_k = '0;
        if (state_reg == ST_UPD) begin
            case (step_reg)
                3'd0: begin unit_a = s_reg[5]; unit_k = s_reg[4]; end
                3'd1: begin unit_a = s_reg[4]; unit_k = s_reg[3]; end
                3'd2: begin unit_a = s_reg[3]; unit_k = pend_reg[255:128]; end
                3'd3: begin unit_a = s_reg[2]; unit_k = s_reg[6]; end
                3'd4: begin unit_a = s_reg[1]; unit_k = s_reg[0]; end
                3'd5: begin unit_a = s_reg[0]; unit_k = pend_reg[127:0]; end
                default: ;
            endcase
        end else if (state_reg == ST_KS) begin
            if (step_reg == 3'd0) begin
                unit_a = s_reg[3] ^ s_reg[5];
                unit_k = s_reg[0];
            end else begin
                unit_a = s_reg[4] ^ s_reg[6];
                unit_k = s_reg[2];
            end
        end
    end

    assign cur_byte  = pay_reg[{bidx_reg[2:0], 3'b000} +: 8];
    assign ks_byte   = ks_reg[{fill_reg[4:0], 3'b000} +: 8];
    assign enc_byte  = cur_byte ^ ks_byte;
    assign push_byte = (op_reg == ars_pkg::OP_MSG && dir_reg) ? enc_byte : cur_byte;

    always_comb begin
        state_next      = state_reg;
        s_next          = s_reg;
        new_next        = new_reg;
        pend_next       = pend_reg;
        ks_next         = ks_reg;
        fill_next       = fill_reg;
        ad_total_next   = ad_total_reg;
        msg_total_next  = msg_total_reg;
        prev_op_next    = prev_op_reg;
        op_next         = op_reg;
        pay_next        = pay_reg;
        n_next          = n_reg;
        bidx_next       = bidx_reg;
        step_next       = step_reg;
        rounds_next     = rounds_reg;
        ks_fresh_next   = ks_fresh_reg;
        tag_len_next    = tag_len_reg;
        widx_next       = widx_reg;
        res_data_next   = res_data_reg;
        res_bytes_next  = res_bytes_reg;
        res_tag_next    = res_tag_reg;
        res_status_next = res_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    op_next         = ars_pkg::opcode_t'(opcode);
                    pay_next        = payload;
                    n_next          = byte_count;
                    bidx_next       = '0;
                    step_next       = '0;
                    ks_fresh_next   = 1'b0;
                    widx_next       = '0;
                    res_data_next   = '0;
                    res_bytes_next  = '0;
                    res_tag_next    = 1'b0;
                    res_status_next = 1'b0;
                    case (ars_pkg::opcode_t'(opcode))
                        ars_pkg::OP_INIT: begin
                            s_next[0]      = k1_blk;
                            s_next[1]      = n_blk;
                            s_next[2]      = ars_pkg::Z0_BLK;
                            s_next[3]      = k0_blk;
                            s_next[4]      = ars_pkg::Z1_BLK;
                            s_next[5]      = n_blk ^ k1_blk;
                            s_next[6]      = '0;
                            pend_next      = {ars_pkg::Z1_BLK, ars_pkg::Z0_BLK};
                            fill_next      = '0;
                            ad_total_next  = '0;
                            msg_total_next = '0;
                            prev_op_next   = ars_pkg::OP_INIT;
                            rounds_next    = ars_pkg::SETUP_ROUNDS;
                            state_next     = ST_UPD;
                        end
                        ars_pkg::OP_TAG: begin
                            prev_op_next = ars_pkg::OP_TAG;
                            res_tag_next = 1'b1;
                            res_bytes_next = 4'd8;
                            if (fill_reg != '0) begin
                                rounds_next  = 5'd1;
                                tag_len_next = 1'b0;
                            end else begin
                                pend_next    = {ars_pkg::bitlen(msg_total_reg),
                                                ars_pkg::bitlen(ad_total_reg)};
                                rounds_next  = ars_pkg::SETUP_ROUNDS;
                                tag_len_next = 1'b1;
                            end
                            state_next = ST_UPD;
                        end
                        default: begin
                            if (byte_count > 4'd8) begin
                                res_status_next = 1'b1;
                                state_next      = ST_RESP;
                            end else begin
                                prev_op_next = ars_pkg::opcode_t'(opcode);
                                if (ars_pkg::opcode_t'(opcode) == ars_pkg::OP_MSG) begin
                                    msg_total_next = msg_total_reg + {60'd0, byte_count};
                                    res_bytes_next = byte_count;
                                end else begin
                                    ad_total_next  = ad_total_reg + {60'd0, byte_count};
                                end
                                // operation change pads and absorbs the partial block
                                if (fill_reg != '0 && prev_op_reg != ars_pkg::opcode_t'(opcode))
                                begin
                                    rounds_next = 5'd1;
                                    state_next  = ST_UPD;
                                end else begin
                                    state_next  = ST_BYTE;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_UPD: begin
                if (step_reg != ars_pkg::LAST_STEP) begin
                    new_next[step_reg] = unit_y;
                    step_next = step_reg + 3'd1;
                end else begin
                    s_next[0] = s_reg[6] ^ s_reg[1];
                    s_next[1] = new_reg[5];
                    s_next[2] = new_reg[4];
                    s_next[3] = new_reg[3];
                    s_next[4] = new_reg[2];
                    s_next[5] = new_reg[1];
                    s_next[6] = new_reg[0];
                    step_next   = '0;
                    rounds_next = rounds_reg - 5'd1;
                    if (rounds_reg == 5'd1) begin
                        pend_next = '0;
                        fill_next = '0;
                        case (op_reg)
                            ars_pkg::OP_INIT: state_next = ST_FOLD;
                            ars_pkg::OP_TAG: begin
                                if (tag_len_reg) begin
                                    state_next = ST_FIN;
                                end else begin
                                    pend_next    = {ars_pkg::bitlen(msg_total_reg),
                                                    ars_pkg::bitlen(ad_total_reg)};
                                    rounds_next  = ars_pkg::SETUP_ROUNDS;
                                    tag_len_next = 1'b1;
                                end
                            end
                            default: state_next = ST_BYTE;
                        endcase
                    end
                end
            end

            ST_KS: begin
                if (step_reg == 3'd0) begin
                    ks_next[127:0] = unit_y;
                    step_next      = 3'd1;
                end else begin
                    ks_next[255:128] = unit_y;
                    step_next        = '0;
                    ks_fresh_next    = 1'b1;
                    state_next       = ST_BYTE;
                end
            end

            ST_BYTE: begin
                if (bidx_reg == n_reg) begin
                    state_next = ST_RESP;
                end else if (op_reg == ars_pkg::OP_MSG && fill_reg == '0 && !ks_fresh_reg) begin
                    step_next  = '0;
                    state_next = ST_KS;
                end else begin
                    if (op_reg == ars_pkg::OP_MSG)
                        res_data_next[{bidx_reg[2:0], 3'b000} +: 8] = enc_byte;
                    pend_next[{fill_reg[4:0], 3'b000} +: 8] = push_byte;
                    fill_next     = fill_reg + 6'd1;
                    bidx_next     = bidx_reg + 4'd1;
                    ks_fresh_next = 1'b0;
                    if (fill_reg == 6'd31) begin
                        rounds_next = 5'd1;
                        step_next   = '0;
                        state_next  = ST_UPD;
                    end
                end
            end

            ST_FOLD: begin
                s_next[0] = s_reg[0] ^ k0_blk;
                s_next[1] = s_reg[1] ^ k0_blk;
                s_next[2] = s_reg[2] ^ k1_blk;
                s_next[3] = s_reg[3] ^ k0_blk;
                s_next[4] = s_reg[4] ^ k0_blk;
                s_next[5] = s_reg[5] ^ k1_blk;
                s_next[6] = s_reg[6] ^ k1_blk;
                state_next = ST_RESP;
            end

            ST_FIN: begin
                ks_next[127:0]   = s_reg[0] ^ s_reg[1] ^ s_reg[2] ^ s_reg[3];
                ks_next[255:128] = s_reg[4] ^ s_reg[5] ^ s_reg[6];
                widx_next        = '0;
                state_next       = ST_RESP;
            end

            ST_RESP: begin
                if (out_ready) begin
                    if (res_tag_reg && widx_reg != 2'd3)
                        widx_next = widx_reg + 2'd1;
                    else
                        state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < 4; i++) key_reg[i] <= '0;
            nonce_lo_reg <= '0;
            nonce_hi_reg <= '0;
            dir_reg      <= 1'b0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                ars_pkg::CFG_KEY0:      key_reg[0]   <= cfg_data;
                ars_pkg::CFG_KEY1:      key_reg[1]   <= cfg_data;
                ars_pkg::CFG_KEY2:      key_reg[2]   <= cfg_data;
                ars_pkg::CFG_KEY3:      key_reg[3]   <= cfg_data;
                ars_pkg::CFG_NONCE_LO:  nonce_lo_reg <= cfg_data;
                ars_pkg::CFG_NONCE_HI:  nonce_hi_reg <= cfg_data;
                ars_pkg::CFG_DIRECTION: dir_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < 7; i++) s_reg[i] <= '0;
            pend_reg      <= '0;
            ks_reg        <= '0;
            fill_reg      <= '0;
            ad_total_reg  <= '0;
            msg_total_reg <= '0;
            prev_op_reg   <= ars_pkg::OP_INIT;
            op_reg        <= ars_pkg::OP_INIT;
            bidx_reg      <= '0;
            n_reg         <= '0;
            step_reg      <= '0;
            rounds_reg    <= '0;
            ks_fresh_reg  <= 1'b0;
            tag_len_reg   <= 1'b0;
            widx_reg      <= '0;
            res_tag_reg   <= 1'b0;
            res_status_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            s_reg         <= s_next;
            pend_reg      <= pend_next;
            ks_reg        <= ks_next;
            fill_reg      <= fill_next;
            ad_total_reg  <= ad_total_next;
            msg_total_reg <= msg_total_next;
            prev_op_reg   <= prev_op_next;
            op_reg        <= op_next;
            bidx_reg      <= bidx_next;
            n_reg         <= n_next;
            step_reg      <= step_next;
            rounds_reg    <= rounds_next;
            ks_fresh_reg  <= ks_fresh_next;
            tag_len_reg   <= tag_len_next;
            widx_reg      <= widx_next;
            res_tag_reg   <= res_tag_next;
            res_status_reg <= res_status_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk) begin
        new_reg       <= new_next;
        pay_reg       <= pay_next;
        res_data_reg  <= res_data_next;
        res_bytes_reg <= res_bytes_next;
    end

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign out_data  = res_tag_reg ? ks_reg[{widx_reg, 6'b000000} +: 64] : res_data_reg;
    assign out_bytes = res_bytes_reg;
    assign is_tag    = res_tag_reg;
    assign last      = !res_tag_reg || (widx_reg == 2'd3);
    assign status    = res_status_reg;

    // block buffer never holds more than one full block
    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 6'd32)
        else $error("pending fill out of range");

    // a full block is absorbed right away
    a_full_absorbs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 6'd32) |-> (state_reg == ST_UPD))
        else $error("full block not being absorbed");

    // tag words always carry eight bytes and never a reject
    a_tag_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_tag) |-> (out_bytes == 4'd8 && !status))
        else $error("bad tag word");

    // a stalled tag word does not advance
    a_tag_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(widx_reg))
        else $error("tag index moved under stall");

endmodule

`default_nettype wire

// ===== tb/sv/aead_stream_cipher_aes_round_unit_checker.sv =====
// Checker for the AES-round AEAD engine: watches the cfg, in and out channels,
// predicts every result word and compares it. Depends on ars_pkg for codes only.
`timescale 1ns / 1ps

module aead_stream_cipher_aes_round_unit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [63:0] payload,
    input  logic [3:0]  byte_count,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [63:0] out_data,
    input  logic [3:0]  out_bytes,
    input  logic        is_tag,
    input  logic        last,
    input  logic        status,
    output int          fail_count,
    output int          pending_results,
    output int          checked_count
);

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        tag;
        logic        lst;
        logic        rej;
    } result_word_t;

    localparam logic [127:0] INIT_C0 = 128'h428a2f98_d728ae22_71374491_23ef65cd;
    localparam logic [127:0] INIT_C1 = 128'hb5c0fbcf_ec4d3b2f_e9b5dba5_8189dbbc;

    logic [7:0]   sub_tab [0:255];
    logic [63:0]  key_w [0:3];
    logic [63:0]  nonce_lo, nonce_hi;
    logic         decrypt;
    logic [127:0] st [0:6];
    logic [255:0] stream_blk, gather_blk;
    int           gather_fill;
    logic [63:0]  ad_total, msg_total;
    ars_pkg::opcode_t last_op;
    result_word_t result_q [$];

    function automatic logic [7:0] dbl(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] r;
        r = 8'h00;
        for (int i = 0; i < 8; i++)
        begin
            if (b[i]) r ^= a;
            a = dbl(a);
        end
        return r;
    endfunction

    // S-box built from the field inverse (x^254) plus the affine map
    initial
    begin
        logic [7:0] p, r;
        for (int x = 0; x < 256; x++)
        begin
            p = x[7:0];
            r = 8'h01;
            for (int i = 1; i < 8; i++)
            begin
                p = gf_mul(p, p);
                r = gf_mul(r, p);
            end
            sub_tab[x] = r ^ {r[6:0], r[7]} ^ {r[5:0], r[7:6]} ^ {r[4:0], r[7:5]}
                         ^ {r[3:0], r[7:4]} ^ 8'h63;
        end
    end

    function automatic logic [127:0] aes_round(input logic [127:0] a, input logic [127:0] k);
        logic [127:0] t, o;
        logic [7:0]   b0, b1, b2, b3;
        for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
                t[8*(r+4*c) +: 8] = sub_tab[a[8*(r+4*((c+r)%4)) +: 8]];
        for (int c = 0; c < 4; c++)
        begin
            b0 = t[32*c +: 8];
            b1 = t[32*c+8 +: 8];
            b2 = t[32*c+16 +: 8];
            b3 = t[32*c+24 +: 8];
            o[32*c +: 8]    = dbl(b0) ^ dbl(b1) ^ b1 ^ b2 ^ b3;
            o[32*c+8 +: 8]  = b0 ^ dbl(b1) ^ dbl(b2) ^ b2 ^ b3;
            o[32*c+16 +: 8] = b0 ^ b1 ^ dbl(b2) ^ dbl(b3) ^ b3;
            o[32*c+24 +: 8] = dbl(b0) ^ b0 ^ b1 ^ b2 ^ dbl(b3);
        end
        return o ^ k;
    endfunction

    task automatic mix_state(input logic [127:0] x0, input logic [127:0] x1);
        logic [127:0] nx [0:6];
        nx[6] = aes_round(st[5], st[4]);
        nx[5] = aes_round(st[4], st[3]);
        nx[4] = aes_round(st[3], x1);
        nx[3] = aes_round(st[2], st[6]);
        nx[2] = aes_round(st[1], st[0]);
        nx[1] = aes_round(st[0], x0);
        nx[0] = st[6] ^ st[1];
        for (int i = 0; i < 7; i++) st[i] = nx[i];
    endtask

    task automatic absorb_block();
        mix_state(gather_blk[127:0], gather_blk[255:128]);
        gather_blk  = '0;
        gather_fill = 0;
    endtask

    task automatic gather_byte(input logic [7:0] v);
        gather_blk[8*gather_fill +: 8] = v;
        gather_fill++;
        if (gather_fill == 32) absorb_block();
    endtask

    function automatic logic [127:0] length_blk(input logic [63:0] total);
        return {61'd0, total, 3'd0};
    endfunction

    task automatic predict_word(input ars_pkg::opcode_t op, input logic [63:0] pl,
                                input logic [3:0] n);
        logic [127:0] k0, k1, nn, ta, tb;
        logic [63:0]  res;
        logic [7:0]   b, o;
        case (op)
            ars_pkg::OP_INIT:
            begin
                k0 = {key_w[1], key_w[0]};
                k1 = {key_w[3], key_w[2]};
                nn = {nonce_hi, nonce_lo};
                st[0] = k1;  st[1] = nn;      st[2] = INIT_C0; st[3] = k0;
                st[4] = INIT_C1; st[5] = nn ^ k1; st[6] = '0;
                repeat (16) mix_state(INIT_C0, INIT_C1);
                st[0] ^= k0; st[1] ^= k0; st[2] ^= k1; st[3] ^= k0;
                st[4] ^= k0; st[5] ^= k1; st[6] ^= k1;
                gather_blk = '0;
                gather_fill = 0;
                ad_total = '0;
                msg_total = '0;
                last_op = ars_pkg::OP_INIT;
                result_q.push_back('{64'd0, 4'd0, 1'b0, 1'b1, 1'b0});
            end
            ars_pkg::OP_TAG:
            begin
                if (gather_fill != 0) absorb_block();
                repeat (16) mix_state(length_blk(ad_total), length_blk(msg_total));
                ta = st[0] ^ st[1] ^ st[2] ^ st[3];
                tb = st[4] ^ st[5] ^ st[6];
                last_op = ars_pkg::OP_TAG;
                result_q.push_back('{ta[63:0],   4'd8, 1'b1, 1'b0, 1'b0});
                result_q.push_back('{ta[127:64], 4'd8, 1'b1, 1'b0, 1'b0});
                result_q.push_back('{tb[63:0],   4'd8, 1'b1, 1'b0, 1'b0});
                result_q.push_back('{tb[127:64], 4'd8, 1'b1, 1'b1, 1'b0});
            end
            default:
            begin
                if (n > 4'd8)
                    // oversize count: rejected, nothing moves
                    result_q.push_back('{64'd0, 4'd0, 1'b0, 1'b1, 1'b1});
                else
                begin
                    // switching between AD and message pads out a partial block
                    if (gather_fill != 0 && last_op != op) absorb_block();
                    last_op = op;
                    if (op == ars_pkg::OP_AD)
                    begin
                        for (int i = 0; i < n; i++) gather_byte(pl[8*i +: 8]);
                        ad_total += {60'd0, n};
                        result_q.push_back('{64'd0, 4'd0, 1'b0, 1'b1, 1'b0});
                    end
                    else
                    begin
                        res = '0;
                        for (int i = 0; i < n; i++)
                        begin
                            b = pl[8*i +: 8];
                            if (gather_fill == 0)
                                stream_blk = {aes_round(st[4] ^ st[6], st[2]),
                                              aes_round(st[3] ^ st[5], st[0])};
                            o = b ^ stream_blk[8*gather_fill +: 8];
                            res[8*i +: 8] = o;
                            gather_byte(decrypt ? o : b);
                        end
                        msg_total += {60'd0, n};
                        result_q.push_back('{res, n, 1'b0, 1'b1, 1'b0});
                    end
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: mismatch on %s: expected %h, got %h", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 4; i++) key_w[i] = '0;
            for (int i = 0; i < 7; i++) st[i] = '0;
            nonce_lo = '0;
            nonce_hi = '0;
            decrypt = 1'b0;
            stream_blk = '0;
            gather_blk = '0;
            gather_fill = 0;
            ad_total = '0;
            msg_total = '0;
            last_op = ars_pkg::OP_INIT;
            result_q.delete();
            fail_count = 0;
            pending_results = 0;
            checked_count = 0;
        end
        else
        begin
            // results first: they belong to words accepted earlier
            if (out_valid && out_ready)
            begin
                if (result_q.size() == 0)
                begin
                    $display("%0t: result word with none expected: data %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    want = result_q.pop_front();
                    check_field("out_data", want.data, out_data);
                    check_field("out_bytes", {60'd0, want.nbytes}, {60'd0, out_bytes});
                    check_field("is_tag", {63'd0, want.tag}, {63'd0, is_tag});
                    check_field("last", {63'd0, want.lst}, {63'd0, last});
                    check_field("status", {63'd0, want.rej}, {63'd0, status});
                    checked_count++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    ars_pkg::CFG_KEY0:      key_w[0] = cfg_data;
                    ars_pkg::CFG_KEY1:      key_w[1] = cfg_data;
                    ars_pkg::CFG_KEY2:      key_w[2] = cfg_data;
                    ars_pkg::CFG_KEY3:      key_w[3] = cfg_data;
                    ars_pkg::CFG_NONCE_LO:  nonce_lo = cfg_data;
                    ars_pkg::CFG_NONCE_HI:  nonce_hi = cfg_data;
                    ars_pkg::CFG_DIRECTION: decrypt = cfg_data[0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                predict_word(ars_pkg::opcode_t'(opcode), payload, byte_count);
            pending_results = result_q.size();
        end
    end

endmodule

// ===== tb/sv/aead_stream_cipher_aes_round_unit_tb.sv =====
// Top of the AES-round AEAD engine testbench: clock, reset, stimulus and verdict.
// Depends on ars_pkg, the engine and aead_stream_cipher_aes_round_unit_checker.
`timescale 1ns / 1ps

module aead_stream_cipher_aes_round_unit_tb;

    // cycles with no transfer on any channel before giving up
    localparam int STALL_LIMIT = 4000;
    localparam int WORD_TARGET = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = '0;
    logic [63:0] payload = '0;
    logic [3:0]  byte_count = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [63:0] out_data;
    logic [3:0]  out_bytes;
    logic        is_tag;
    logic        last;
    logic        status;

    int fail_count, pending_results, checked_count;
    int words_sent = 0;
    int sessions = 0;
    int burst_left = 0;
    int idle_cycles = 0;
    int rx_phase = 0;
    int rx_mode = 0;

    aead_stream_cipher_aes_round_unit dut (.*);

    aead_stream_cipher_aes_round_unit_checker checker_i (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Receiver: switches at random between always-ready, coin-flip, and mostly stalled
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                default: out_ready <= ($urandom_range(0, 5) == 0);
            endcase
            rx_phase <= rx_phase + 1;
            if (rx_phase % 64 == 63) rx_mode <= $urandom_range(0, 2);
        end
    end

    // Watchdog: ends the run when nothing moves on any channel for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // One word on the in channel. Sender runs in bursts; between bursts valid may drop
    // for a random gap. Inside a burst valid stays high and only the word's fields change.
    task automatic send_word(input ars_pkg::opcode_t op, input logic [63:0] pl,
                             input logic [3:0] n);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        burst_left--;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        payload    <= pl;
        byte_count <= n;
        do @(posedge clk); while (!in_ready);
        words_sent++;
    endtask

    // Hold off the sender until every expected result word has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_results != 0) @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_setup(input logic [63:0] k0, input logic [63:0] k1,
                              input logic [63:0] k2, input logic [63:0] k3,
                              input logic [63:0] nl, input logic [63:0] nh,
                              input logic dir);
        drain();
        write_reg(ars_pkg::CFG_KEY0, k0);
        write_reg(ars_pkg::CFG_KEY1, k1);
        write_reg(ars_pkg::CFG_KEY2, k2);
        write_reg(ars_pkg::CFG_KEY3, k3);
        write_reg(ars_pkg::CFG_NONCE_LO, nl);
        write_reg(ars_pkg::CFG_NONCE_HI, nh);
        write_reg(ars_pkg::CFG_DIRECTION, {63'd0, dir});
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Mostly legal counts; now and then an oversize one to hit the reject path
    function automatic logic [3:0] rand_count();
        if ($urandom_range(0, 11) == 0) return 4'($urandom_range(9, 15));
        return 4'($urandom_range(0, 8));
    endfunction

    // A random session: init, some AD, some message, finalize. Some skip the
    // init or the finalize, and a few sprinkle stray ops in the middle.
    task automatic random_session();
        int n_ad, n_msg;
        sessions++;
        n_ad  = $urandom_range(0, 10);
        n_msg = $urandom_range(0, 16);
        if ($urandom_range(0, 9) != 0) send_word(ars_pkg::OP_INIT, rand64(), rand_count());
        for (int i = 0; i < n_ad; i++) send_word(ars_pkg::OP_AD, rand64(), rand_count());
        for (int i = 0; i < n_msg; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_word(ars_pkg::OP_AD, rand64(), rand_count());
            else
                send_word(ars_pkg::OP_MSG, rand64(), rand_count());
        end
        if ($urandom_range(0, 7) != 0) send_word(ars_pkg::OP_TAG, rand64(), rand_count());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset state, then extremes and the odd corners
        sessions = 1;
        send_word(ars_pkg::OP_MSG, '1, 4'd8);               // data before any init
        send_word(ars_pkg::OP_TAG, '0, 4'd0);               // finalize on reset state
        load_setup('1, '1, '1, '1, '1, '1, 1'b0);
        send_word(ars_pkg::OP_INIT, '1, 4'd15);             // init ignores payload and count
        send_word(ars_pkg::OP_AD, '1, 4'd8);
        send_word(ars_pkg::OP_AD, 64'h0123_4567_89ab_cdef, 4'd5);
        send_word(ars_pkg::OP_AD, '0, 4'd0);
        send_word(ars_pkg::OP_AD, '1, 4'd9);                // rejected
        send_word(ars_pkg::OP_MSG, '0, 4'd0);               // op change with no bytes pads
        for (int i = 0; i < 5; i++) send_word(ars_pkg::OP_MSG, '1, 4'd8);   // crosses a block
        send_word(ars_pkg::OP_MSG, 64'h8000_0000_0000_0001, 4'd15);       // rejected
        send_word(ars_pkg::OP_AD, 64'h55aa_55aa_55aa_55aa, 4'd3);          // back to AD
        send_word(ars_pkg::OP_TAG, '1, 4'd8);               // pad partial block, then tag
        send_word(ars_pkg::OP_AD, 64'hdead_beef_cafe_f00d, 4'd8);          // after finalize
        send_word(ars_pkg::OP_TAG, '0, 4'd0);

        // Decrypt, zero key, and a direction flip in the middle of a block
        load_setup('0, '0, '0, '0, '0, '0, 1'b1);
        send_word(ars_pkg::OP_INIT, '0, 4'd0);
        send_word(ars_pkg::OP_MSG, 64'hfedc_ba98_7654_3210, 4'd7);
        drain();
        write_reg(ars_pkg::CFG_DIRECTION, 64'd0);
        send_word(ars_pkg::OP_MSG, '1, 4'd8);
        send_word(ars_pkg::OP_MSG, '1, 4'd1);
        send_word(ars_pkg::OP_TAG, '0, 4'd0);
        send_word(ars_pkg::OP_INIT, '0, 4'd0);
        send_word(ars_pkg::OP_TAG, '0, 4'd0);               // empty AD and message

        // Random: fresh key and direction every few sessions
        while (words_sent < WORD_TARGET)
        begin
            if ($urandom_range(0, 2) == 0)
                load_setup(rand64(), rand64(), rand64(), rand64(), rand64(), rand64(),
                           1'($urandom_range(0, 1)));
            random_session();
        end

        drain();
        repeat (20) @(posedge clk);
        $display("Ran %0d input words in %0d sessions, %0d result words checked.",
                 words_sent, sessions, checked_count);
        $display("Both directions, rejects, pad on op change and keystream wrap exercised.");
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
sv/ars_pkg.sv
sv/ars_aes_round.sv
sv/aead_stream_cipher_aes_round_unit.sv
tb/sv/aead_stream_cipher_aes_round_unit_checker.sv
tb/sv/aead_stream_cipher_aes_round_unit_tb.sv
